// File: hw/rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared widths, types, register indexes and saturation helper for the
// third-order forward Euler plant stepper.
// ----------------------------------------------------------------------------
package sse_pkg;

  // data format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_WIDTH = DATA_WIDTH - 1;

  // digit-serial multiplier geometry
  localparam int DIGIT_W    = 8;
  localparam int NUM_DIGITS = DATA_WIDTH / DIGIT_W;
  localparam int DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int PART_W     = DATA_WIDTH + DIGIT_W + 1;   // operand times one digit
  localparam int HI_W       = PART_W;                     // upper product accumulator
  localparam int STEP_SUM_W = HI_W + 1;                   // one digit step sum
  localparam int Q_W        = 2 * DATA_WIDTH - FRAC_BITS; // rounded product
  localparam int SUM_W      = Q_W + 2;                    // derivative / state sum

  // configuration
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd6;

  localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(655);

  // rounding constant, half an lsb of the result
  localparam logic signed [STEP_SUM_W-1:0] ROUND_HALF =
    STEP_SUM_W'(1) << (FRAC_BITS - 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [STEP_WIDTH-1:0]        step_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [Q_W-1:0]        prod_t;

  // clamp a wide sum to the signed data range
  function automatic data_t sat_data(input sum_t v);
    logic all_zero;
    logic all_one;
    begin
      all_zero = (v[SUM_W-1:DATA_WIDTH-1] == '0);
      all_one  = (v[SUM_W-1:DATA_WIDTH-1] == '1);
      if (all_zero || all_one) begin
        sat_data = v[DATA_WIDTH-1:0];
      end else if (v[SUM_W-1]) begin
        sat_data = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
        sat_data = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
    end
  endfunction

  // widen helpers
  function automatic sum_t ext_data(input data_t v);
    ext_data = {{(SUM_W-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
  endfunction

  function automatic sum_t ext_prod(input prod_t v);
    ext_prod = {{(SUM_W-Q_W){v[Q_W-1]}}, v};
  endfunction

endpackage

// File: hw/rtl/state_space_euler_step.sv
// A new drive sample is accepted only in the idle state, once the last result is in the output register.
// The engine has a single shared multiplier: nine products per item, each built
// digit-serially (32 x 8 bits per cycle) and then added in an accumulate step.
// Reset (rst_n low, synchronous): plant state cleared to zero, coefficients to
// zero, time step to 655, no result pending. Config writes are taken every cycle.
// ----------------------------------------------------------------------------
// state_space_euler_step
// Third-order companion-form plant advanced by one forward Euler step per
// drive sample, in signed fixed point with rounding and saturation.
// ----------------------------------------------------------------------------
module state_space_euler_step (
  input  logic                clk,
  input  logic                rst_n,
  // drive sample channel
  input  logic                in_valid,
  output logic                in_ready,
  input  sse_pkg::data_t      in_drive_sample,
  // plant output channel
  output logic                out_valid,
  input  logic                out_ready,
  output sse_pkg::data_t      out_plant_output,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  sse_pkg::cfg_idx_t   cfg_index,
  input  sse_pkg::data_t      cfg_data
);
  import sse_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  // product schedule: six derivative terms, then three step products
  typedef enum logic [3:0] {
    OP_A0,
    OP_B0,
    OP_A1,
    OP_B1,
    OP_A2,
    OP_B2,
    OP_D0,
    OP_D1,
    OP_D2
  } op_t;

  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NUM_DIGITS - 1);

  state_t                   state_r;
  op_t                      op_r;
  logic [DIG_CNT_W-1:0]     dig_r;

  data_t                    coef_a_r [3];
  data_t                    coef_b_r [3];
  step_t                    step_r;
  data_t                    x_r      [3];
  data_t                    dx_r     [3];
  data_t                    u_r;
  sum_t                     acc_r;

  // digit-serial multiplier registers
  data_t                    mcand_r;
  logic [DATA_WIDTH-1:0]    mplr_r;
  logic signed [HI_W-1:0]   hi_r;
  logic [DATA_WIDTH-1:0]    lo_r;

  data_t                    out_data_r;
  logic                     out_valid_r;

  logic                     in_accept;
  logic                     out_take;
  op_t                      op_nxt;
  data_t                    mcand_nxt;
  logic [DATA_WIDTH-1:0]    mplr_nxt;
  data_t                    u_src;

  logic signed [DIGIT_W:0]      digit_s;
  logic signed [PART_W-1:0]     part;
  logic signed [STEP_SUM_W-1:0] step_sum;
  logic signed [HI_W-1:0]       hi_nxt;
  logic [DATA_WIDTH-1:0]        lo_nxt;
  prod_t                        prod_q;
  sum_t                         addend;
  sum_t                         sum_nxt;

  assign in_ready         = (state_r == ST_IDLE);
  assign in_accept        = in_valid && in_ready;
  assign out_take         = out_valid_r && out_ready;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_plant_output = out_data_r;

  // operands of the next product to load
  always_comb begin
    u_src = in_accept ? in_drive_sample : u_r;
    if (in_accept) begin
      op_nxt = OP_A0;
    end else begin
      case (op_r)
        OP_A0:   op_nxt = OP_B0;
        OP_B0:   op_nxt = OP_A1;
        OP_A1:   op_nxt = OP_B1;
        OP_B1:   op_nxt = OP_A2;
        OP_A2:   op_nxt = OP_B2;
        OP_B2:   op_nxt = OP_D0;
        OP_D0:   op_nxt = OP_D1;
        OP_D1:   op_nxt = OP_D2;
        default: op_nxt = OP_A0;
      endcase
    end
    case (op_nxt)
      OP_A0:   begin mcand_nxt = coef_a_r[0]; mplr_nxt = x_r[2]; end
      OP_B0:   begin mcand_nxt = coef_b_r[0]; mplr_nxt = u_src;  end
      OP_A1:   begin mcand_nxt = coef_a_r[1]; mplr_nxt = x_r[2]; end
      OP_B1:   begin mcand_nxt = coef_b_r[1]; mplr_nxt = u_src;  end
      OP_A2:   begin mcand_nxt = coef_a_r[2]; mplr_nxt = x_r[2]; end
      OP_B2:   begin mcand_nxt = coef_b_r[2]; mplr_nxt = u_src;  end
      OP_D0:   begin mcand_nxt = dx_r[0];     mplr_nxt = {1'b0, step_r}; end
      OP_D1:   begin mcand_nxt = dx_r[1];     mplr_nxt = {1'b0, step_r}; end
      default: begin mcand_nxt = dx_r[2];     mplr_nxt = {1'b0, step_r}; end
    endcase
  end

  // one digit step: low digits unsigned, top digit signed
  always_comb begin
    digit_s  = {(dig_r == DIG_LAST) ? mplr_r[DIGIT_W-1] : 1'b0, mplr_r[DIGIT_W-1:0]};
    part     = mcand_r * digit_s;
    step_sum = {hi_r[HI_W-1], hi_r} + {part[PART_W-1], part}
               + ((dig_r == '0) ? ROUND_HALF : '0);
    hi_nxt   = {{(DIGIT_W-1){step_sum[STEP_SUM_W-1]}}, step_sum[STEP_SUM_W-1:DIGIT_W]};
    lo_nxt   = {step_sum[DIGIT_W-1:0], lo_r[DATA_WIDTH-1:DIGIT_W]};
  end

  // rounded product and the shared accumulate adder
  always_comb begin
    prod_q = {hi_r[DATA_WIDTH-1:0], lo_r[DATA_WIDTH-1:FRAC_BITS]};
    case (op_r)
      OP_D0:   addend = ext_data(x_r[0]);
      OP_D1:   addend = ext_data(x_r[1]);
      OP_D2:   addend = ext_data(x_r[2]);
      default: addend = acc_r;
    endcase
    sum_nxt = addend + ext_prod(prod_q);
  end

  // sequencer, datapath and registered output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_A0;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= STEP_RESET;
      for (int i = 0; i < 3; i++) begin
        coef_a_r[i] <= '0;
        coef_b_r[i] <= '0;
        x_r[i]      <= '0;
      end
    end else begin
      // configuration transaction
      if (cfg_valid) begin
        case (cfg_index)
          REG_COEF_A0:   coef_a_r[0] <= cfg_data;
          REG_COEF_A1:   coef_a_r[1] <= cfg_data;
          REG_COEF_A2:   coef_a_r[2] <= cfg_data;
          REG_COEF_B0:   coef_b_r[0] <= cfg_data;
          REG_COEF_B1:   coef_b_r[1] <= cfg_data;
          REG_COEF_B2:   coef_b_r[2] <= cfg_data;
          REG_TIME_STEP: step_r      <= cfg_data[STEP_WIDTH-1:0];
          default:       ;
        endcase
      end

      // the output state reloads the register itself
      if (out_take && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            u_r     <= in_drive_sample;
            acc_r   <= '0;
            op_r    <= op_nxt;
            mcand_r <= mcand_nxt;
            mplr_r  <= mplr_nxt;
            hi_r    <= '0;
            lo_r    <= '0;
            dig_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          hi_r   <= hi_nxt;
          lo_r   <= lo_nxt;
          mplr_r <= mplr_r >> DIGIT_W;
          dig_r  <= dig_r + 1'b1;
          if (dig_r == DIG_LAST) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          case (op_r)
            OP_B0: begin
              dx_r[0] <= sat_data(sum_nxt);
              acc_r   <= ext_data(x_r[0]);
            end
            OP_B1: begin
              dx_r[1] <= sat_data(sum_nxt);
              acc_r   <= ext_data(x_r[1]);
            end
            OP_B2:   dx_r[2] <= sat_data(sum_nxt);
            OP_D0:   x_r[0]  <= sat_data(sum_nxt);
            OP_D1:   x_r[1]  <= sat_data(sum_nxt);
            OP_D2:   x_r[2]  <= sat_data(sum_nxt);
            default: acc_r   <= sum_nxt;
          endcase
          if (op_r == OP_D2) begin
            state_r <= ST_OUT;
          end else begin
            op_r    <= op_nxt;
            mcand_r <= mcand_nxt;
            mplr_r  <= mplr_nxt;
            hi_r    <= '0;
            lo_r    <= '0;
            dig_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= x_r[2];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // a result appears only on leaving the output state
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result raised outside the output state");

  // accumulate follows exactly after the last digit
  a_acc_after_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> ($past(state_r) == ST_MUL && $past(dig_r) == DIG_LAST))
    else $error("accumulate reached before all digits were processed");

  // digit counter advances by one on every multiply cycle
  a_digit_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && $past(state_r) == ST_MUL)
      |-> dig_r == DIG_CNT_W'($past(dig_r) + 1'b1))
    else $error("digit counter skipped a step");

  // no item accepted while the engine is busy
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_ACC) |=> !(in_accept && $past(op_r) != OP_D2))
    else $error("input accepted during a computation");

endmodule
